// File: src/multi_ant_grid_walker_unit_defines.svh
// Assertion helpers for the RTL top file of the grid walker.
`ifndef MULTI_ANT_GRID_WALKER_UNIT_DEFINES_SVH
`define MULTI_ANT_GRID_WALKER_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define MAGW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define MAGW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/magw_pkg.sv
`default_nettype none

package magw_pkg;

  // Grid and ant limits.
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int MAX_ANTS = 16;

  // Field widths fixed by the interface.
  localparam int COORD_W = 8;
  localparam int SLOT_W  = 4;
  localparam int DIM_W   = 9;
  localparam int CNT_W   = 5;

  // Derived sizes.
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int WORD_W     = 16;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int RAM_DEPTH  = (CELL_COUNT + WORD_W - 1) / WORD_W;
  localparam int RAM_AW     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int ANT_IDX_W  = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
  localparam int ANT_CNT_W  = $clog2(MAX_ANTS + 1);
  localparam int COL_LIM    = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_LIM    = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  // Commands.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Headings.
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ANTS   = 2'd2;

  typedef logic [CELL_W-1:0] cell_idx_t;

  // A dimension register of zero acts as one; a large one saturates at the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > lim) begin
      res = lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic cell_idx_t cell_index(input logic [COORD_W-1:0] c,
                                           input logic [COORD_W-1:0] r);
    cell_idx_t r_ext;
    r_ext = CELL_W'(r);
    return cell_idx_t'(r_ext * CELL_W'(MAX_COLS)) + CELL_W'(c);
  endfunction

  function automatic logic [RAM_AW-1:0] word_addr(input cell_idx_t idx);
    return RAM_AW'(idx >> BIT_W);
  endfunction

endpackage

`default_nettype wire

// File: src/magw_ram.sv
`default_nettype none

module magw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: src/multi_ant_grid_walker_unit.sv
// Several Langton's ants walking on a wrapping bit grid.
//
// Commands arrive as beats on the s_ channel (command in s_tuser) and every
// command returns exactly one beat on the m_ channel: cell_value in m_tdata
// and bad_request in m_tuser. Grid size and the number of taking-part ants are
// set through the write port by the user while the block is idle; the block does not enforce this.
//
// The grid lives in a single-port RAM of 16-bit words; one sequencer drives its
// port, and one cell-index and move unit serves each ant in turn.
// A place goes straight from idle to the done state, a read via a read state.
// A step reads the cell under each ant in turn and moves it, then flips each
// distinct occupied cell by read-modify-write (address, then write state); an
// ant sharing a cell with an earlier one only passes the address state.
// Clear, and also leaving reset, sweeps the RAM one word per cycle. No beat is
// accepted during the sweep; configuration writes are.
//
// The result sits in an output register. While the receiver stalls, the block
// keeps it and accepts the next command, but it holds back that command's
// result until the register is free.
`default_nettype none
`include "multi_ant_grid_walker_unit_defines.svh"

module multi_ant_grid_walker_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command channel.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // ant_slot[3:0], col[11:4], row[19:12], zero pad
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  // Result channel.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // cell_value[0], zero pad
  output logic             m_tuser,   // bad_request[0]
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_G_ADDR  = 3'd3;
  localparam logic [2:0] S_G_DATA  = 3'd4;
  localparam logic [2:0] S_F_ADDR  = 3'd5;
  localparam logic [2:0] S_F_WRITE = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state;
  logic [magw_pkg::RAM_AW-1:0] clr_addr;
  logic clr_reply;

  logic [magw_pkg::DIM_W-1:0] grid_width;
  logic [magw_pkg::DIM_W-1:0] grid_height;
  logic [magw_pkg::CNT_W-1:0] active_ants;

  logic [magw_pkg::COORD_W-1:0] ant_col     [magw_pkg::MAX_ANTS];
  logic [magw_pkg::COORD_W-1:0] ant_row     [magw_pkg::MAX_ANTS];
  logic [1:0]                   ant_heading [magw_pkg::MAX_ANTS];
  magw_pkg::cell_idx_t          pending     [magw_pkg::MAX_ANTS];
  logic                         is_first    [magw_pkg::MAX_ANTS];

  logic [magw_pkg::ANT_IDX_W-1:0] ai;
  logic [magw_pkg::BIT_W-1:0]     req_bit;
  logic res_value;
  logic res_bad;

  // RAM port.
  logic                         ram_we;
  logic [magw_pkg::RAM_AW-1:0]  ram_addr;
  logic [magw_pkg::WORD_W-1:0]  ram_wdata;
  logic [magw_pkg::WORD_W-1:0]  ram_rdata;

  // Input fields.
  logic [1:0]                    s_cmd;
  logic [magw_pkg::SLOT_W-1:0]   s_slot;
  logic [magw_pkg::COORD_W-1:0]  s_col;
  logic [magw_pkg::COORD_W-1:0]  s_row;
  magw_pkg::cell_idx_t           s_idx;
  logic                          s_in_grid;

  // Shared per-ant unit.
  logic [magw_pkg::DIM_W-1:0]     eff_w;
  logic [magw_pkg::DIM_W-1:0]     eff_h;
  logic [magw_pkg::ANT_CNT_W-1:0] n_eff;
  logic [magw_pkg::COORD_W-1:0]   cur_col;
  logic [magw_pkg::COORD_W-1:0]   cur_row;
  logic [1:0]                     cur_head;
  magw_pkg::cell_idx_t            cur_idx;
  magw_pkg::cell_idx_t            pend_idx;
  logic                           rd_bit;
  logic [1:0]                     new_head;
  logic [magw_pkg::COORD_W-1:0]   nxt_col;
  logic [magw_pkg::COORD_W-1:0]   nxt_row;
  logic                           seen;
  logic                           last_ant;

  assign s_cmd  = s_tuser;
  assign s_slot = s_tdata[3:0];
  assign s_col  = s_tdata[11:4];
  assign s_row  = s_tdata[19:12];
  assign s_idx  = magw_pkg::cell_index(s_col, s_row);

  assign eff_w = magw_pkg::clamp_dim(grid_width, magw_pkg::DIM_W'(magw_pkg::COL_LIM));
  assign eff_h = magw_pkg::clamp_dim(grid_height, magw_pkg::DIM_W'(magw_pkg::ROW_LIM));

  always_comb begin
    if (int'(active_ants) > magw_pkg::MAX_ANTS) begin
      n_eff = magw_pkg::ANT_CNT_W'(magw_pkg::MAX_ANTS);
    end else begin
      n_eff = magw_pkg::ANT_CNT_W'(active_ants);
    end
  end

  assign s_in_grid = ({1'b0, s_col} < eff_w) && ({1'b0, s_row} < eff_h);

  assign s_tready = (state == S_IDLE);

  assign cur_col  = ant_col[ai];
  assign cur_row  = ant_row[ai];
  assign cur_head = ant_heading[ai];
  assign cur_idx  = magw_pkg::cell_index(cur_col, cur_row);
  assign pend_idx = pending[ai];
  assign rd_bit   = ram_rdata[cur_idx[magw_pkg::BIT_W-1:0]];
  assign new_head = rd_bit ? (cur_head + 2'd1) : (cur_head - 2'd1);
  assign last_ant = (magw_pkg::ANT_CNT_W'(ai) + magw_pkg::ANT_CNT_W'(1)) == n_eff;

  // One move along the new heading. An ant left outside a shrunken grid wraps
  // to the opposite edge of the current grid.
  always_comb begin
    nxt_col = cur_col;
    nxt_row = cur_row;
    case (new_head)
      magw_pkg::HEAD_UP: begin
        nxt_row = ({1'b0, cur_row} >= eff_h - 9'd1) ? '0 : cur_row + 8'd1;
      end
      magw_pkg::HEAD_RIGHT: begin
        nxt_col = ({1'b0, cur_col} >= eff_w - 9'd1) ? '0 : cur_col + 8'd1;
      end
      magw_pkg::HEAD_DOWN: begin
        nxt_row = (cur_row == '0 || {1'b0, cur_row} >= eff_h) ?
                  magw_pkg::COORD_W'(eff_h - 9'd1) : cur_row - 8'd1;
      end
      default: begin
        nxt_col = (cur_col == '0 || {1'b0, cur_col} >= eff_w) ?
                  magw_pkg::COORD_W'(eff_w - 9'd1) : cur_col - 8'd1;
      end
    endcase
  end

  // An ant whose cell was already claimed by an earlier ant in this generation
  // does not flip it again.
  always_comb begin
    seen = 1'b0;
    for (int k = 0; k < magw_pkg::MAX_ANTS; k++) begin
      if ((magw_pkg::ANT_IDX_W'(k) < ai) && (pending[k] == cur_idx)) begin
        seen = 1'b1;
      end
    end
  end

  // RAM port sequencing.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_IDLE: begin
        ram_addr = magw_pkg::word_addr(s_idx);
      end
      S_G_ADDR: begin
        ram_addr = magw_pkg::word_addr(cur_idx);
      end
      S_F_ADDR: begin
        ram_addr = magw_pkg::word_addr(pend_idx);
      end
      S_F_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = magw_pkg::word_addr(pend_idx);
        ram_wdata = ram_rdata ^
                    (magw_pkg::WORD_W'(1) << pend_idx[magw_pkg::BIT_W-1:0]);
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  magw_ram #(
    .WIDTH(magw_pkg::WORD_W),
    .DEPTH(magw_pkg::RAM_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      grid_width  <= 9'd256;
      grid_height <= 9'd256;
      active_ants <= 5'd1;
      ai          <= '0;
      m_tvalid    <= 1'b0;
      for (int k = 0; k < magw_pkg::MAX_ANTS; k++) begin
        ant_col[k]     <= '0;
        ant_row[k]     <= '0;
        ant_heading[k] <= magw_pkg::HEAD_UP;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          magw_pkg::CFG_WIDTH:  grid_width  <= cfg_wdata;
          magw_pkg::CFG_HEIGHT: grid_height <= cfg_wdata;
          magw_pkg::CFG_ANTS:   active_ants <= cfg_wdata[magw_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      // In the done state the output register is refilled below instead.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (clr_addr == magw_pkg::RAM_AW'(magw_pkg::RAM_DEPTH - 1)) begin
            clr_addr  <= '0;
            res_value <= 1'b0;
            res_bad   <= 1'b0;
            state     <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + magw_pkg::RAM_AW'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            res_value <= 1'b0;
            req_bit   <= s_idx[magw_pkg::BIT_W-1:0];
            case (s_cmd)
              magw_pkg::CMD_CLEAR: begin
                for (int k = 0; k < magw_pkg::MAX_ANTS; k++) begin
                  ant_heading[k] <= magw_pkg::HEAD_UP;
                end
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              magw_pkg::CMD_PLACE: begin
                if (!s_in_grid || int'(s_slot) >= magw_pkg::MAX_ANTS) begin
                  res_bad <= 1'b1;
                end else begin
                  res_bad <= 1'b0;
                  ant_col[magw_pkg::ANT_IDX_W'(s_slot)] <= s_col;
                  ant_row[magw_pkg::ANT_IDX_W'(s_slot)] <= s_row;
                end
                state <= S_DONE;
              end
              magw_pkg::CMD_STEP: begin
                res_bad <= 1'b0;
                ai      <= '0;
                state   <= (n_eff == '0) ? S_DONE : S_G_ADDR;
              end
              default: begin
                if (!s_in_grid) begin
                  res_bad <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  res_bad <= 1'b0;
                  state   <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= ram_rdata[req_bit];
          state     <= S_DONE;
        end
        S_G_ADDR: begin
          state <= S_G_DATA;
        end
        S_G_DATA: begin
          pending[ai]     <= cur_idx;
          is_first[ai]    <= !seen;
          ant_heading[ai] <= new_head;
          ant_col[ai]     <= nxt_col;
          ant_row[ai]     <= nxt_row;
          if (last_ant) begin
            ai    <= '0;
            state <= S_F_ADDR;
          end else begin
            ai    <= ai + magw_pkg::ANT_IDX_W'(1);
            state <= S_G_ADDR;
          end
        end
        S_F_ADDR: begin
          if (is_first[ai]) begin
            state <= S_F_WRITE;
          end else if (last_ant) begin
            ai    <= '0;
            state <= S_DONE;
          end else begin
            ai <= ai + magw_pkg::ANT_IDX_W'(1);
          end
        end
        S_F_WRITE: begin
          if (last_ant) begin
            ai    <= '0;
            state <= S_DONE;
          end else begin
            ai    <= ai + magw_pkg::ANT_IDX_W'(1);
            state <= S_F_ADDR;
          end
        end
        S_DONE: begin
          // Wait here while the previous result is still held by the receiver.
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {7'b0, res_value};
            m_tuser   <= res_bad;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MAGW_ASSERT_IMP(a_flip_once, clk, rst, state == S_F_WRITE, is_first[ai], "flip of a repeated cell")
  `MAGW_ASSERT_IMP(a_flip_rmw, clk, rst, state == S_F_WRITE, $past(state) == S_F_ADDR, "flip write without read")
  `MAGW_ASSERT_IMP(a_ram_write, clk, rst, ram_we, state == S_CLEAR || state == S_F_WRITE, "stray grid write")
  `MAGW_ASSERT_NXT(a_accept_busy, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  `MAGW_ASSERT_IMP(a_reject_zero, clk, rst, m_tvalid && m_tuser, !m_tdata[0], "rejected with cell set")

endmodule

`default_nettype wire

// File: test/ant_walk_checker.sv
// Watches the command, result and register-write channels of the grid walker,
// keeps its own copy of the grid, the ants and the registers, and compares
// every result beat with the outcome that the oldest open command should give.
module ant_walk_checker
  import magw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [23:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,
  input  logic              m_tuser,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_wdata,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  typedef struct packed {
    logic cell_value;
    logic bad_request;
  } walk_outcome_t;

  walk_outcome_t pending_outcomes[$];

  bit               grid_cells [CELL_COUNT];
  logic [COORD_W-1:0] col_of     [MAX_ANTS];
  logic [COORD_W-1:0] row_of     [MAX_ANTS];
  logic [1:0]         heading_of [MAX_ANTS];

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [CNT_W-1:0] ants_reg;

  int unsigned error_count;
  int unsigned beats_seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] grid walker mismatch at result beat %0d: %s", $time, beats_seen, what);
    error_count++;
  endtask

  // A zero register acts as one; anything above the limit saturates.
  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v, input int unsigned cap);
    if (v == '0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  function automatic int unsigned cell_at(input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row);
    return row * MAX_COLS + col;
  endfunction

  function automatic void wipe_grid();
    grid_cells = '{default: 1'b0};
    foreach (heading_of[k]) heading_of[k] = HEAD_UP;
  endfunction

  // One generation: every taking-part ant turns on the cell as it was before
  // the generation and moves; each occupied cell is inverted once at the end.
  function automatic void run_generation();
    int unsigned w, h, n, i, j, c, r;
    int unsigned under [MAX_ANTS];
    bit shared_cell;
    w = dim_in_use(width_reg, COL_LIM);
    h = dim_in_use(height_reg, ROW_LIM);
    n = (ants_reg > MAX_ANTS) ? MAX_ANTS : ants_reg;
    for (i = 0; i < n; i++) begin
      under[i] = cell_at(col_of[i], row_of[i]);
      heading_of[i] = grid_cells[under[i]] ? heading_of[i] + 2'd1 : heading_of[i] - 2'd1;
      c = col_of[i];
      r = row_of[i];
      // An ant left outside a shrunken grid wraps to the opposite edge.
      case (heading_of[i])
        HEAD_UP:    r = (r >= h - 1) ? 0 : r + 1;
        HEAD_RIGHT: c = (c >= w - 1) ? 0 : c + 1;
        HEAD_DOWN:  r = (r == 0 || r >= h) ? h - 1 : r - 1;
        default:    c = (c == 0 || c >= w) ? w - 1 : c - 1;
      endcase
      col_of[i] = COORD_W'(c);
      row_of[i] = COORD_W'(r);
    end
    for (i = 0; i < n; i++) begin
      shared_cell = 1'b0;
      for (j = 0; j < i; j++)
        if (under[j] == under[i]) shared_cell = 1'b1;
      if (!shared_cell) grid_cells[under[i]] = ~grid_cells[under[i]];
    end
  endfunction

  function automatic walk_outcome_t command_outcome(input logic [1:0] cmd,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [COORD_W-1:0] col,
                                                    input logic [COORD_W-1:0] row);
    walk_outcome_t res;
    bit on_grid;
    res = '0;
    on_grid = (col < dim_in_use(width_reg, COL_LIM)) && (row < dim_in_use(height_reg, ROW_LIM));
    case (cmd)
      CMD_CLEAR: wipe_grid();
      CMD_PLACE: begin
        if (!on_grid) begin
          res.bad_request = 1'b1;
        end else begin
          col_of[slot] = col;
          row_of[slot] = row;
        end
      end
      CMD_STEP: run_generation();
      default: begin
        if (!on_grid) res.bad_request = 1'b1;
        else res.cell_value = grid_cells[cell_at(col, row)];
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    walk_outcome_t got;
    walk_outcome_t want;
    if (rst) begin
      wipe_grid();
      foreach (col_of[k]) begin
        col_of[k] = '0;
        row_of[k] = '0;
      end
      width_reg  = DIM_W'(256);
      height_reg = DIM_W'(256);
      ants_reg   = CNT_W'(1);
      pending_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.cell_value  = m_tdata[0];
        got.bad_request = m_tuser;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result beat with no command waiting for it");
        end else begin
          want = pending_outcomes.pop_front();
          if (got.cell_value !== want.cell_value)
            report_mismatch($sformatf("cell_value %b, expected %b",
                                      got.cell_value, want.cell_value));
          if (got.bad_request !== want.bad_request)
            report_mismatch($sformatf("bad_request %b, expected %b",
                                      got.bad_request, want.bad_request));
        end
        beats_seen++;
      end
      if (s_tvalid && s_tready)
        pending_outcomes.insert(pending_outcomes.size(),
                                command_outcome(s_tuser, s_tdata[3:0], s_tdata[11:4],
                                                s_tdata[19:12]));
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg  = cfg_wdata;
          CFG_HEIGHT: height_reg = cfg_wdata;
          CFG_ANTS:   ants_reg   = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= error_count;
    outstanding <= pending_outcomes.size();
  end

endmodule

// File: test/tb_multi_ant_grid_walker_unit.sv
// Top of the grid walker test. It drives commands and register writes, runs
// the result receiver, and gives the verdict; all prediction and comparison
// happens in the checker instantiated beside the block.
module tb_multi_ant_grid_walker_unit;
  import magw_pkg::*;

  // A long receiver stall, in cycles. It is far longer than a full generation
  // of sixteen ants, so the block fills its output register and the command
  // behind it and has to stall the command channel.
  localparam int unsigned LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_wdata;

  int unsigned mismatches;
  int unsigned outstanding;

  // Effective grid size and ant count as the stimulus believes them to be.
  int unsigned cur_w = 256;
  int unsigned cur_h = 256;
  int unsigned cur_n = 1;

  // When set, neither side idles. holds_asked and holds_done hand a long
  // stall request from the stimulus to the receiver process.
  bit          no_idle = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;

  always #1 clk = ~clk;

  multi_ant_grid_walker_unit DUT (.*);

  ant_walk_checker walk_check (.*);

  // Idle length for either side: mostly nothing or a few cycles, now and then
  // a long gap.
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one command beat and returns at the edge where it is taken. When
  // no gap is drawn, tvalid simply stays high for the next beat.
  task automatic issue(input logic [1:0] cmd, input int unsigned slot,
                       input int unsigned col, input int unsigned row);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'd0, 8'(row), 8'(col), 4'(slot)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering beats and waits until every command has had its result.
  // The count from the checker is registered, hence the edge before the first
  // look.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes all three registers once the block has gone quiet. Every command
  // returns a beat, so a drained block is idle; a short pause covers the tail.
  task automatic configure(input logic [8:0] w, input logic [8:0] h, input logic [8:0] n);
    drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_ANTS;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = (w == 0) ? 1 : ((w > COL_LIM) ? COL_LIM : w);
    cur_h = (h == 0) ? 1 : ((h > ROW_LIM) ? ROW_LIM : h);
    cur_n = (n[CNT_W-1:0] > MAX_ANTS) ? MAX_ANTS : n[CNT_W-1:0];
  endtask

  // Result receiver: bursts of ready with stalls of random length between
  // them, a long hold whenever the stimulus asks for one, and ready all the
  // time while no_idle is set.
  initial begin : receiver
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (no_idle) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        stall = gap_len();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase, k, roll;
    logic [8:0] w_reg, h_reg, n_reg;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_CLEAR;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset registers: a 256 by 256 grid and
    // one ant. Corners of the grid first, with a lone ant walking off them.
    issue(CMD_READ, 0, 0, 0);
    issue(CMD_READ, 0, 255, 255);
    issue(CMD_PLACE, 0, 255, 255);
    issue(CMD_STEP, 0, 0, 0);
    issue(CMD_READ, 0, 255, 255);
    issue(CMD_STEP, 0, 0, 0);
    // The last slot is placed although it does not take part yet.
    issue(CMD_PLACE, 15, 0, 0);
    issue(CMD_READ, 0, 254, 255);

    // Width zero acts as one column, an oversized height saturates, and an
    // oversized ant count means all sixteen slots. Slot 0 now stands outside
    // the grid, and most slots share the origin cell.
    configure(9'd0, 9'd511, 9'd31);
    issue(CMD_PLACE, 3, 1, 0);
    issue(CMD_READ, 0, 1, 5);
    issue(CMD_READ, 0, 0, 255);
    issue(CMD_STEP, 0, 0, 0);
    issue(CMD_STEP, 0, 0, 0);
    issue(CMD_READ, 0, 0, 0);
    issue(CMD_CLEAR, 0, 0, 0);
    issue(CMD_READ, 0, 0, 0);

    // No ant takes part: a generation changes nothing.
    configure(9'd256, 9'd256, 9'd0);
    issue(CMD_STEP, 0, 0, 0);
    issue(CMD_READ, 0, 254, 254);

    // A single-row grid with a saturated width and two ants.
    configure(9'd300, 9'd1, 9'd2);
    issue(CMD_PLACE, 1, 10, 0);
    issue(CMD_STEP, 0, 0, 0);
    issue(CMD_STEP, 0, 0, 0);
    issue(CMD_READ, 0, 255, 0);
    issue(CMD_READ, 0, 10, 0);
    issue(CMD_PLACE, 2, 0, 1);

    // Random part: phases of one register setting each. Small grids keep the
    // ants crossing each other's trails; the odd tiny, skinny or extreme grid
    // leaves ants stranded outside it.
    for (phase = 0; phase < 16; phase++) begin
      roll = $urandom_range(0, 5);
      case (roll)
        0: begin
          w_reg = 9'($urandom_range(1, 6));
          h_reg = 9'($urandom_range(1, 6));
        end
        1, 2: begin
          w_reg = 9'($urandom_range(4, 24));
          h_reg = 9'($urandom_range(4, 24));
        end
        3: begin
          w_reg = 9'($urandom_range(1, 256));
          h_reg = 9'($urandom_range(1, 256));
        end
        4: begin
          w_reg = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(256, 511));
          h_reg = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(256, 511));
        end
        default: begin
          w_reg = 9'($urandom_range(1, 3));
          h_reg = 9'($urandom_range(64, 256));
        end
      endcase
      n_reg = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 31)) : 9'($urandom_range(1, 16));
      configure(w_reg, h_reg, n_reg);
      no_idle = (phase % 4 == 3);

      // One phase starts with the receiver holding off for a long stretch
      // while commands keep coming.
      if (phase == 5) holds_asked++;

      if ($urandom_range(0, 2) == 0)
        issue(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
      for (k = 0; k < cur_n; k++)
        issue(CMD_PLACE, k, $urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));

      for (k = 0; k < 80; k++) begin
        // Once in the run the sender waits for every result before going on.
        if (phase == 9 && k == 40) drain();
        roll = $urandom_range(0, 99);
        if (roll < 1)
          issue(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
        else if (roll < 46)
          issue(CMD_STEP, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
        else if (roll < 76)
          issue(CMD_READ, $urandom_range(0, 15), $urandom_range(0, cur_w - 1),
                $urandom_range(0, cur_h - 1));
        else if (roll < 88)
          issue(CMD_PLACE, $urandom_range(0, 15), $urandom_range(0, cur_w - 1),
                $urandom_range(0, cur_h - 1));
        else if (roll < 94)
          issue(CMD_READ, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
        else
          issue(CMD_PLACE, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
    no_idle = 1'b0;

    // Let the last results arrive, then a little slack for anything stray.
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("multi_ant_grid_walker_unit test passed");
    end else begin
      $display("multi_ant_grid_walker_unit test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, including the clearing
  // sweeps after reset and after each clear command.
  initial begin : watchdog
    #4000000;
    $display("multi_ant_grid_walker_unit test failed");
    $finish;
  end

endmodule

// File: multi_ant_grid_walker_unit.f
+incdir+src
src/magw_pkg.sv
src/magw_ram.sv
src/multi_ant_grid_walker_unit.sv
test/ant_walk_checker.sv
test/tb_multi_ant_grid_walker_unit.sv
